FILE: rtl/linear_equation_stream_solver_defines.svh
// Assertion macros for the linear equation stream solver.
// Uses clk and rst of the module that includes it; no other dependencies.
`ifndef LINEAR_EQUATION_STREAM_SOLVER_DEFINES_SVH
`define LINEAR_EQUATION_STREAM_SOLVER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LESS_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LESS_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: rtl/less_pkg.sv
// Shared types and constants for the linear equation stream solver.
// No dependencies; used by the controller, the datapath and the top level.
package less_pkg;

  localparam logic [7:0] CH_0     = 8'h30;  // '0'
  localparam logic [7:0] CH_9     = 8'h39;  // '9'
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='

  localparam logic [1:0] KIND_UNIQUE   = 2'd0;
  localparam logic [1:0] KIND_NONE     = 2'd1;
  localparam logic [1:0] KIND_INFINITE = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic char_en;    // process the accepted character
    logic flush;      // add pending number to the constant sum
    logic div_start;  // load divider operands
    logic div_step;   // one restoring-division step
    logic finish;     // load result word, clear parse state
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_last;   // current step is the final one
  } status_t;

endpackage

FILE: rtl/less_stream_if.sv
// Valid/ready channel interfaces for the solver: character input and result output.
// Depends on nothing but plain logic types.
interface less_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface less_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         solution_kind;
  logic signed [31:0] solution_value;

  modport source (output valid, output solution_kind, output solution_value, input ready);
  modport sink   (input valid, input solution_kind, input solution_value, output ready);
endinterface

FILE: rtl/linear_equation_stream_solver.sv
// Linear equation stream solver: one equation in x, one character per word.
// Input channel in_ch carries char_code and last_char; output channel out_ch carries
// solution_kind (0 unique, 1 no solution, 2 infinite) and solution_value.
// A character word is taken every cycle while an equation is being read; digits build
// numbers, a number before 'x' feeds the x coefficient, others the constant, and terms
// after '=' change sign. Number and sums saturate at +-(2^(ACC_WIDTH-1)-1).
// After the word marked last, the controller runs one flush step, one divider setup step
// and ACC_WIDTH-1 restoring-division steps (one quotient bit each), then loads the
// output register once it is free. in_ch.ready is low from the last character until
// the result is loaded, so the next equation starts the cycle after the load; the result
// value is -constant/coefficient truncated toward zero and saturated to 32 bits, and 0
// when there is no unique value. If out_ch stalls, the result word holds and characters
// of the next equation are still taken; once that equation ends, its result waits in the
// controller with in_ch.ready low until the register is free. Synchronous reset rst
// clears all sums, the sign state and out_ch.valid.
// Depends on less_pkg, less_stream_if, less_ctrl, less_dp and the defines header.
`include "linear_equation_stream_solver_defines.svh"

module linear_equation_stream_solver #(
  parameter int ACC_WIDTH = 48
) (
  input  logic        clk,
  input  logic        rst,
  less_in_if.sink     in_ch,
  less_out_if.source  out_ch
);

  less_pkg::cmd_t    cmd;
  less_pkg::status_t status;

  less_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_char),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  less_dp #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .char_code      (in_ch.char_code),
    .solution_kind  (out_ch.solution_kind),
    .solution_value (out_ch.solution_value)
  );

  `LESS_ASSERT_NEXT(a_last_blocks_input,
    in_ch.valid && in_ch.ready && in_ch.last_char, !in_ch.ready,
    "input still ready after last character")
  `LESS_ASSERT_NOW(a_result_from_finish,
    $rose(out_ch.valid), $past(cmd.finish),
    "result valid without a finish command")
  `LESS_ASSERT_NOW(a_no_value_when_not_unique,
    out_ch.valid && (out_ch.solution_kind != less_pkg::KIND_UNIQUE),
    out_ch.solution_value == 32'sd0,
    "value nonzero for non-unique result")

endmodule

FILE: rtl/less_ctrl.sv
// Sequencer for the solver: parse, flush, divider setup, divide, hand off result.
// Depends on less_pkg for the command and status structs.
module less_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output less_pkg::cmd_t    cmd,
  input  less_pkg::status_t status
);

  localparam logic [2:0] S_PARSE = 3'd0;
  localparam logic [2:0] S_FLUSH = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state, state_next;
  logic       accept;
  logic       slot_free;

  assign in_ready  = (state == S_PARSE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.char_en   = accept;
    case (state)
      S_PARSE: begin
        if (accept && in_last) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the word
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_PARSE;
        end
      end
      default: state_next = S_PARSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_PARSE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/less_dp.sv
// Datapath for the solver: character parsing, saturating sums, restoring divider,
// result saturation and output register. Depends on less_pkg.
module less_dp #(
  parameter int ACC_WIDTH = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  less_pkg::cmd_t       cmd,
  output less_pkg::status_t    status,
  input  logic [7:0]           char_code,
  output logic [1:0]           solution_kind,
  output logic signed [31:0]   solution_value
);

  localparam int MW = ACC_WIDTH - 1;                 // magnitude width
  localparam int CW = $clog2(MW + 1);                // step counter width
  localparam int QW = (MW > 33) ? MW : 33;           // quotient compare width
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};

  logic signed [ACC_WIDTH-1:0] x_coef, const_sum;
  logic [ACC_WIDTH-1:0]        num_acc;
  logic                        on_left, term_pos, prev_zero;

  logic [MW-1:0] divisor, quo, rem;
  logic          neg;
  logic [CW-1:0] count;

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] a,
    input logic signed [ACC_WIDTH-1:0] b
  );
    logic signed [ACC_WIDTH:0] s;
    logic signed [ACC_WIDTH:0] hi;
    s  = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
    hi = {1'b0, ACC_MAX};
    if (s > hi) return ACC_MAX;
    else if (s < -hi) return -ACC_MAX;
    else return s[ACC_WIDTH-1:0];
  endfunction

  // decode and term arithmetic
  logic                        is_digit;
  logic [3:0]                  digit;
  logic [ACC_WIDTH+3:0]        prod;
  logic [ACC_WIDTH-1:0]        x_mag;
  logic signed [ACC_WIDTH-1:0] x_term, c_term;
  logic                        term_sign_pos;

  always_comb begin
    is_digit      = (char_code >= less_pkg::CH_0) && (char_code <= less_pkg::CH_9);
    digit         = char_code[3:0];
    prod          = {1'b0, num_acc, 3'b000} + {3'b000, num_acc, 1'b0}
                  + {{ACC_WIDTH{1'b0}}, digit};
    term_sign_pos = (on_left == term_pos);
    x_mag         = ((num_acc == '0) && !prev_zero) ? ACC_WIDTH'(1) : num_acc;
    x_term        = term_sign_pos ? $signed(x_mag) : -$signed(x_mag);
    c_term        = term_sign_pos ? $signed(num_acc) : -$signed(num_acc);
  end

  // divider step
  logic [MW:0] rem_shift, rem_diff;
  logic        fits;

  always_comb begin
    rem_shift = {rem, quo[MW-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    fits      = (rem_shift >= {1'b0, divisor});
  end

  assign status.div_last = (count == CW'(1));

  // result formatting
  logic [QW-1:0]      qx;
  logic signed [31:0] q_sat;
  logic [1:0]         kind;

  always_comb begin
    qx = QW'(quo);
    if (neg) begin
      if (qx > QW'(33'h0_8000_0000)) q_sat = 32'sh8000_0000;
      else q_sat = -$signed(qx[31:0]);
    end else begin
      if (qx > QW'(33'h0_7FFF_FFFF)) q_sat = 32'sh7FFF_FFFF;
      else q_sat = $signed(qx[31:0]);
    end
    if (x_coef == '0) begin
      kind = (const_sum == '0) ? less_pkg::KIND_INFINITE : less_pkg::KIND_NONE;
    end else begin
      kind = less_pkg::KIND_UNIQUE;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      x_coef    <= '0;
      const_sum <= '0;
      num_acc   <= '0;
      on_left   <= 1'b1;
      term_pos  <= 1'b1;
      prev_zero <= 1'b0;
    end else if (cmd.flush) begin
      const_sum <= sat_add(const_sum, c_term);
      num_acc   <= '0;
    end else if (cmd.char_en) begin
      prev_zero <= (char_code == less_pkg::CH_0);
      if (is_digit) begin
        // saturate once the number would pass the accumulator limit
        if (prod > {4'b0000, ACC_MAX}) num_acc <= ACC_MAX;
        else num_acc <= prod[ACC_WIDTH-1:0];
      end else if (char_code == less_pkg::CH_X) begin
        x_coef  <= sat_add(x_coef, x_term);
        num_acc <= '0;
      end else if (char_code == less_pkg::CH_MINUS) begin
        const_sum <= sat_add(const_sum, c_term);
        num_acc   <= '0;
        term_pos  <= 1'b0;
      end else if (char_code == less_pkg::CH_PLUS) begin
        const_sum <= sat_add(const_sum, c_term);
        num_acc   <= '0;
        term_pos  <= 1'b1;
      end else if (char_code == less_pkg::CH_EQ) begin
        const_sum <= sat_add(const_sum, c_term);
        num_acc   <= '0;
        on_left   <= 1'b0;
        term_pos  <= 1'b1;
      end
    end
  end

  // divider and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.div_start) begin
      count <= CW'(MW);
    end else if (cmd.div_step) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      divisor <= x_coef[ACC_WIDTH-1] ? MW'(-x_coef) : MW'(x_coef);
      quo     <= const_sum[ACC_WIDTH-1] ? MW'(-const_sum) : MW'(const_sum);
      rem     <= '0;
      // -C / X is negative when C and X share a sign
      neg     <= (x_coef[ACC_WIDTH-1] == const_sum[ACC_WIDTH-1]);
    end else if (cmd.div_step) begin
      rem <= fits ? rem_diff[MW-1:0] : rem_shift[MW-1:0];
      quo <= {quo[MW-2:0], fits};
    end
    if (cmd.finish) begin
      solution_kind  <= kind;
      solution_value <= (kind == less_pkg::KIND_UNIQUE) ? q_sat : 32'sd0;
    end
  end

endmodule

FILE: tb/sv/less_solution_checker.sv
// Watches both channels of the linear equation solver, predicts each solution word
// and compares it field by field. Depends on less_pkg and the less_in_if/less_out_if
// interfaces.
module less_solution_checker #(
  parameter int ACC_WIDTH = 48
) (
  input  logic clk,
  input  logic rst,
  less_in_if   in_ch,
  less_out_if  out_ch,
  output int   mismatches,
  output int   outstanding
);
  import less_pkg::*;

  localparam longint SUM_MAX = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } solution_t;

  solution_t expected_solutions[$];

  longint x_coef;
  longint const_sum;
  longint number;
  bit     left_side;
  bit     term_plus;
  bit     after_zero;
  int     error_count;

  function automatic longint saturating_sum(longint a, longint b);
    if (b > 0 && a > SUM_MAX - b) return SUM_MAX;
    if (b < 0 && a < -SUM_MAX - b) return -SUM_MAX;
    return a + b;
  endfunction

  // A term counts positive when its sign agrees with the side it stands on.
  function automatic longint side_signed(longint v);
    return (left_side == term_plus) ? v : -v;
  endfunction

  function automatic void flush_number();
    const_sum = saturating_sum(const_sum, side_signed(number));
    number = 0;
  endfunction

  function automatic void clear_equation();
    x_coef     = 0;
    const_sum  = 0;
    number     = 0;
    left_side  = 1'b1;
    term_plus  = 1'b1;
    after_zero = 1'b0;
  endfunction

  function automatic void take_char(logic [7:0] c, logic last);
    solution_t sol;
    longint    digit;
    longint    quotient;
    bit        was_zero;
    was_zero = after_zero;
    if (c >= CH_0 && c <= CH_9) begin
      digit = longint'(c - CH_0);
      if (number > (SUM_MAX - digit) / 10) number = SUM_MAX;
      else number = number * 10 + digit;
    end else if (c == CH_X) begin
      // bare x means 1, but a zero right before x keeps it 0
      if (number == 0 && !was_zero) number = 1;
      x_coef = saturating_sum(x_coef, side_signed(number));
      number = 0;
    end else if (c == CH_MINUS) begin
      flush_number();
      term_plus = 1'b0;
    end else if (c == CH_PLUS) begin
      flush_number();
      term_plus = 1'b1;
    end else if (c == CH_EQ) begin
      flush_number();
      left_side = 1'b0;
      term_plus = 1'b1;
    end
    after_zero = (c == CH_0);
    if (!last) return;

    flush_number();
    sol.value = '0;
    if (x_coef == 0) begin
      sol.kind = (const_sum == 0) ? KIND_INFINITE : KIND_NONE;
    end else begin
      quotient = (-const_sum) / x_coef;
      if (quotient > 64'sd2147483647) quotient = 64'sd2147483647;
      if (quotient < -64'sd2147483648) quotient = -64'sd2147483648;
      sol.kind  = KIND_UNIQUE;
      sol.value = quotient[31:0];
    end
    expected_solutions.push_back(sol);
    clear_equation();
  endfunction

  always @(posedge clk) begin : watch
    solution_t head;
    if (rst) begin
      clear_equation();
      expected_solutions.delete();
      error_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_solutions.size() == 0) begin
          if (error_count < 10)
            $display("unexpected solution word: kind %0d value %0d",
                     out_ch.solution_kind, out_ch.solution_value);
          error_count++;
        end else begin
          head = expected_solutions.pop_front();
          if (out_ch.solution_kind !== head.kind || out_ch.solution_value !== head.value) begin
            if (error_count < 10)
              $display("solution mismatch: kind exp %0d got %0d, value exp %0d got %0d",
                       head.kind, out_ch.solution_kind, head.value, out_ch.solution_value);
            error_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) take_char(in_ch.char_code, in_ch.last_char);
    end
    mismatches  <= error_count;
    outstanding <= expected_solutions.size();
  end

endmodule

FILE: tb/sv/tb.sv
// Top of the linear equation solver testbench: clock, reset, equation stimulus with
// random idling and output stalls, and the verdict. Depends on less_pkg, the stream
// interfaces, the solver and less_solution_checker.
module tb;
  import less_pkg::*;

  localparam int ACC_WIDTH   = 48;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_WORDS = 315;

  int idle_by_phase[4]  = '{0, 72, 0, 35};
  int stall_by_phase[4] = '{0, 0, 72, 35};

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   cycle_count = 0;
  int   words_sent = 0;
  int   mismatches;
  int   outstanding;
  logic [7:0] eq_chars[$];

  less_in_if  in_ch ();
  less_out_if out_ch ();

  linear_equation_stream_solver #(.ACC_WIDTH(ACC_WIDTH)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  less_solution_checker #(.ACC_WIDTH(ACC_WIDTH)) i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
    cycle_count  <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("linear_equation_stream_solver verification failed");
      $finish;
    end
  end

  task automatic put_word(logic [7:0] c, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.last_char <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_equation();
    foreach (eq_chars[i]) begin
      put_word(eq_chars[i], i == eq_chars.size() - 1);
      if (eq_chars[i] inside {[CH_0:CH_9], CH_X, CH_PLUS, CH_MINUS, CH_EQ}) words_sent++;
    end
  endtask

  // Hold the sender until every outstanding solution has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic void append_term(bit lead);
    int r;
    int ndig;
    r = $urandom_range(99);
    if (!lead) eq_chars.push_back(r < 50 ? CH_PLUS : CH_MINUS);
    else if (r < 25) eq_chars.push_back(CH_MINUS);
    else if (r < 35) eq_chars.push_back(CH_PLUS);
    r = $urandom_range(99);
    // mostly short numbers, some long enough to saturate the accumulator
    ndig = (r < 20) ? 0 : (r < 30) ? 15 + $urandom_range(3) :
           (r < 36) ? 6 + $urandom_range(6) : 1 + $urandom_range(2);
    repeat (ndig) eq_chars.push_back(CH_0 + 8'($urandom_range(9)));
    if (ndig == 0 || $urandom_range(1) == 1) eq_chars.push_back(CH_X);
  endfunction

  function automatic void compose_equation();
    int r;
    eq_chars.delete();
    r = $urandom_range(99);
    if (r < 10) begin
      // noise, biased toward the printable range that holds the syntax
      repeat (1 + $urandom_range(11))
        eq_chars.push_back($urandom_range(1) ? 8'($urandom_range(CH_PLUS, CH_X))
                                             : 8'($urandom_range(255)));
    end else begin
      append_term(1'b1);
      repeat ($urandom_range(2)) append_term(1'b0);
      if ($urandom_range(9) != 0) begin
        eq_chars.push_back(CH_EQ);
        append_term(1'b1);
        repeat ($urandom_range(2)) append_term(1'b0);
      end
      // break a few equations by overwriting characters
      if (r < 25)
        repeat (1 + $urandom_range(2))
          eq_chars[$urandom_range(eq_chars.size() - 1)] = 8'($urandom_range(255));
    end
  endfunction

  initial begin
    string directed_text[5];
    int    phase_start;
    directed_text   = '{"x", "-", "0x=5", "3x-7=x", "x=9999999999"};
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= '0;
    in_ch.last_char <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_text[k]) begin
      eq_chars.delete();
      for (int j = 0; j < directed_text[k].len(); j++) eq_chars.push_back(directed_text[k][j]);
      send_equation();
    end
    // only ignored characters, at both ends of the code range
    eq_chars = '{8'h00, 8'hFF};
    send_equation();
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct    = idle_by_phase[p];
      stall_pct   = stall_by_phase[p];
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        compose_equation();
        send_equation();
        if ($urandom_range(9) == 0) drain();
      end
      drain();
    end

    repeat (ACC_WIDTH + 8) @(posedge clk);
    if (mismatches == 0)
      $display("linear_equation_stream_solver verification clean");
    else
      $display("linear_equation_stream_solver verification failed");
    $finish;
  end

endmodule
